[hdl/sqlm_pkg.sv]
// sqlm_pkg: shared types and constants for the sql like wildcard matcher
// no dependencies; compiled first
`default_nettype none

package sqlm_pkg;

  localparam int unsigned MAX_PATTERN_DEFAULT = 32;

  localparam logic [7:0] ANY_RUN = 8'h25;
  localparam logic [7:0] ANY_ONE = 8'h5F;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_END    = 2'd3
  } func_e;

  // command broadcast to every cell
  typedef struct packed {
    logic       text;
    logic       restart;
    logic       append;
    logic [7:0] ch;
  } cell_cmd_t;

  // neighbor link: zero-width closure carry and one-byte step
  typedef struct packed {
    logic carry;
    logic step;
  } cell_link_t;

endpackage

`default_nettype wire

[hdl/sqlm_in_if.sv]
// sqlm_in_if: input item channel, valid/ready plus func and char_code
// no dependencies
`default_nettype none

interface sqlm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink (input valid, input func, input char_code, output ready);
endinterface

`default_nettype wire

[hdl/sqlm_out_if.sv]
// sqlm_out_if: result item channel, valid/ready plus matched and status
// no dependencies
`default_nettype none

interface sqlm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic status;

  modport source (output valid, output matched, output status, input ready);
  modport sink (input valid, input matched, input status, output ready);
endinterface

`default_nettype wire

[hdl/sqlm_cfg_if.sv]
// sqlm_cfg_if: configuration write channel for the invert_result register
// no dependencies
`default_nettype none

interface sqlm_cfg_if;
  logic valid;
  logic ready;
  logic invert_result;

  modport source (output valid, output invert_result, input ready);
  modport sink (input valid, input invert_result, output ready);
endinterface

`default_nettype wire

[hdl/sql_like_wildcard_matcher_top.sv]
// sql_like_wildcard_matcher_top: like / not like matcher built as a row of cells
// depends on sqlm_pkg, sqlm_in_if, sqlm_out_if, sqlm_cfg_if, sqlm_cell
//
// Usage:
//   cfg_i writes invert_result (1 = not like); always ready, write only when idle.
//   in_i takes one item per cycle while ready: func 0 appends a pattern byte, 1
//   clears the pattern, 2 streams a text byte, 3 ends the text. Only end of text
//   gives a result item on out_o: matched (xor invert_result) and status (1 when
//   the pattern overflowed MAX_PATTERN bytes; matched is then 0).
//   Throughput is one item per cycle while in_i is ready. A result appears in
//   the cycle after its end item is accepted. Each text byte updates all
//   positions at once in the cell row; zero-width steps over '%' ripple through
//   the cells in the same cycle.
//   The result sits in an output register; in_i stays ready while that
//   register is empty or is being taken, so a stalled receiver holds in_i off
//   only while a result waits.
//   Reset clears the pattern length, the overflow flag, invert_result and the
//   active set to position zero; pattern bytes need no clearing pass.
`default_nettype none

module sql_like_wildcard_matcher_top #(
  parameter int unsigned MAX_PATTERN = sqlm_pkg::MAX_PATTERN_DEFAULT
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  sqlm_in_if.sink     in_i,
  sqlm_out_if.source  out_o,
  sqlm_cfg_if.sink    cfg_i
);
  import sqlm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  logic             accept;
  func_e            func;
  cell_cmd_t        cmd;
  cell_link_t       link [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] closed;

  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             last_q, last_d;
  logic             inv_q;
  logic             ov_q, ov_d;
  logic             matched_q, matched_d;
  logic             status_q, status_d;
  logic             is_full;

  assign func    = func_e'(in_i.func);
  assign in_i.ready = ~ov_q | out_o.ready;
  assign accept  = in_i.valid & in_i.ready;
  assign is_full = (len_q == LEN_W'(MAX_PATTERN));

  assign cmd.text    = accept && (func == FUNC_TEXT);
  assign cmd.append  = accept && (func == FUNC_APPEND);
  assign cmd.restart = accept && (func != FUNC_TEXT);
  assign cmd.ch      = in_i.char_code;

  assign link[0] = '0;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    sqlm_cell #(
      .IDX   (g),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .len_i    (len_q),
      .link_i   (link[g]),
      .link_o   (link[g+1]),
      .closed_o (closed[g])
    );
  end

  assign closed[MAX_PATTERN] = last_q | link[MAX_PATTERN].carry;

  always_comb begin
    len_d     = len_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    ov_d      = ov_q & ~out_o.ready;
    matched_d = matched_q;
    status_d  = status_q;
    if (accept) begin
      case (func)
        FUNC_APPEND: begin
          if (is_full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LEN_W'(1);
          end
          last_d = 1'b0;
        end
        FUNC_CLEAR: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          last_d = 1'b0;
        end
        FUNC_TEXT: begin
          last_d = link[MAX_PATTERN].step;
        end
        FUNC_END: begin
          ov_d      = 1'b1;
          matched_d = ovf_q ? 1'b0 : (closed[len_q] ^ inv_q);
          status_d  = ovf_q ? STATUS_OVERFLOW : STATUS_OK;
          last_d    = 1'b0;
        end
        default: begin
          last_d = last_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      last_q <= 1'b0;
      inv_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      last_q <= last_d;
      ov_q   <= ov_d;
      if (cfg_i.valid && cfg_i.ready) begin
        inv_q <= cfg_i.invert_result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    status_q  <= status_d;
  end

  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = ov_q;
  assign out_o.matched = matched_q;
  assign out_o.status  = status_q;

endmodule

`default_nettype wire

[hdl/sqlm_cell.sv]
// sqlm_cell: one pattern position, holds its byte and its active bit
// depends on sqlm_pkg
`default_nettype none

module sqlm_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = 6
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  sqlm_pkg::cell_cmd_t     cmd_i,
  input  wire [LEN_W-1:0]         len_i,
  input  sqlm_pkg::cell_link_t    link_i,
  output sqlm_pkg::cell_link_t    link_o,
  output logic                    closed_o
);
  import sqlm_pkg::*;

  logic [7:0] byte_q;
  logic       act_q, act_d;
  logic       in_use;
  logic       is_run;
  logic       hit;

  assign in_use   = (len_i > LEN_W'(IDX));
  assign is_run   = (byte_q == ANY_RUN);
  assign hit      = (byte_q == ANY_ONE) || (byte_q == cmd_i.ch);
  assign closed_o = act_q | link_i.carry;

  assign link_o.carry = closed_o & in_use & is_run;
  assign link_o.step  = closed_o & in_use & ~is_run & hit;

  always_comb begin
    act_d = act_q;
    if (cmd_i.restart) begin
      act_d = 1'(IDX == 0);
    end else if (cmd_i.text) begin
      act_d = (closed_o & in_use & is_run) | link_i.step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'(IDX == 0);
    end else begin
      act_q <= act_d;
    end
  end

  // pattern byte, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (len_i == LEN_W'(IDX))) begin
      byte_q <= cmd_i.ch;
    end
  end

endmodule

`default_nettype wire

[hdl/sqlm_checker.sv]
// sqlm_checker: port-level assertions for the matcher, bound to the top level
// depends on sqlm_pkg and sql_like_wildcard_matcher_top
`default_nettype none

module sqlm_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire [1:0] in_func_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire       out_matched_i,
  input wire       out_status_i
);
  import sqlm_pkg::*;

  logic end_acc;
  assign end_acc = in_valid_i && in_ready_i && (func_e'(in_func_i) == FUNC_END);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_matched_i) && $stable(out_status_i))
    else $error("result dropped or changed while stalled");

  // each end item gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |=> out_valid_i)
    else $error("end item gave no result");

  // a result only follows an end item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i && !out_ready_i) |-> $past(end_acc))
    else $error("result without end item");

  // overflowed results report no match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_OVERFLOW) |-> !out_matched_i)
    else $error("overflow result reports a match");

  // input is open whenever the output register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind sql_like_wildcard_matcher_top sqlm_checker u_sqlm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched),
  .out_status_i  (out_o.status)
);

`default_nettype wire
